// ===== hw/rtl/glc_pkg.sv =====
// ----------------------------------------------------------------------------
// glc_pkg: shared types and codes of the glyph LRU cache policy
// Field widths of the item channels and the action codes.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int ACTION_W = 2;
  localparam int GLYPH_W  = 16;
  localparam int SLOT_W   = 8;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [GLYPH_W-1:0]  glyph_t;
  typedef logic [SLOT_W-1:0]   slot_t;

  localparam action_t ACT_LOOKUP = 2'd0;
  localparam action_t ACT_BITMAP = 2'd1;
  localparam action_t ACT_FLUSH  = 2'd2;

endpackage

// ===== hw/rtl/glc_in_if.sv =====
// ----------------------------------------------------------------------------
// glc_in_if: request channel of the glyph LRU cache policy
// Valid/ready channel carrying an action and a glyph code.
// ----------------------------------------------------------------------------
interface glc_in_if;
  import glc_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  glyph_t  glyph_code;

  modport source (output valid, output action, output glyph_code, input ready);
  modport sink   (input valid, input action, input glyph_code, output ready);

endinterface

// ===== hw/rtl/glc_out_if.sv =====
// ----------------------------------------------------------------------------
// glc_out_if: result channel of the glyph LRU cache policy
// Valid/ready channel carrying the outcome of one access.
// ----------------------------------------------------------------------------
interface glc_out_if;
  import glc_pkg::*;

  logic   valid;
  logic   ready;
  logic   hit;
  slot_t  slot_index;
  logic   evicted_valid;
  glyph_t evicted_code;
  logic   needs_render;

  modport source (output valid, output hit, output slot_index, output evicted_valid,
                  output evicted_code, output needs_render, input ready);
  modport sink   (input valid, input hit, input slot_index, input evicted_valid,
                  input evicted_code, input needs_render, output ready);

endinterface

// ===== hw/rtl/glyph_lru_cache_policy_core.sv =====
// ----------------------------------------------------------------------------
// glyph_lru_cache_policy_core: fully associative glyph cache, LRU by stamps
//
// Requests arrive on in_chan (action, glyph_code) and each produces exactly
// one item on out_chan (hit, slot_index, evicted_valid, evicted_code,
// needs_render). A lookup walks the entries through the tag, stamp and
// rendered-flag memories one read per cycle, stopping at a match or after the
// last entry, with the search for a match and the least-recently-stamped
// victim done in the same walk. The memory read port is registered. After the
// scan a lookup passes ST_UPDATE, then ST_EMIT loads its result into the
// output register. A flush sweeps the stamp memory; an unused action code
// answers with zeros.
// One request is in work at a time: in_chan.ready is high only while the
// sequencer is idle, so no new request is taken until the last one is done.
// The output register lets the next request be accepted while a result still
// waits; a result that finds the register occupied waits until out_chan.ready
// frees it.
// After reset a clearing pass empties the stamp memory and no request is
// accepted meanwhile; the stamp counter starts at one.
// ----------------------------------------------------------------------------
module glyph_lru_cache_policy_core #(
  parameter int ENTRIES    = 256,
  parameter int STAMP_BITS = 32,
  parameter int CODE_BITS  = 16
) (
  input  logic clk,
  input  logic rst_n,
  glc_in_if.sink    in_chan,
  glc_out_if.source out_chan
);
  import glc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [IDX_W:0]        cnt_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;
  typedef logic [CODE_BITS-1:0]  code_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   hit;
    slot_t  slot_index;
    logic   evicted_valid;
    glyph_t evicted_code;
    logic   needs_render;
  } result_t;

  // Memories
  code_t  tag_mem   [ENTRIES];
  stamp_t stamp_mem [ENTRIES];
  logic   flag_mem  [ENTRIES];

  code_t  tag_q;
  stamp_t stamp_q;
  logic   flag_q;

  idx_t   rd_addr;
  idx_t   wr_addr;
  logic   stamp_we, tag_we, flag_we;
  stamp_t wr_stamp;
  logic   wr_flag;

  // Sequencer registers
  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  logic    pend_r, pend_nxt;
  idx_t    pidx_r, pidx_nxt;
  action_t act_r, act_nxt;
  code_t   code_r, code_nxt;
  stamp_t  best_stamp_r, best_stamp_nxt;
  idx_t    best_idx_r, best_idx_nxt;
  code_t   best_tag_r, best_tag_nxt;
  logic    found_r, found_nxt;
  idx_t    slot_r, slot_nxt;
  logic    slot_flag_r, slot_flag_nxt;
  logic    clr_reply_r, clr_reply_nxt;
  stamp_t  stamp_cnt_r, stamp_cnt_nxt;
  result_t res_r, res_nxt;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  logic found_now;
  logic last_entry;
  logic evict;
  idx_t upd_slot;

  assign rd_addr    = cnt_r[IDX_W-1:0];
  assign found_now  = pend_r && (stamp_q != '0) && (tag_q == code_r);
  assign last_entry = (pidx_r == IDX_W'(ENTRIES - 1));
  assign evict      = !found_r && (best_stamp_r != '0);
  assign upd_slot   = found_r ? slot_r : best_idx_r;

  always_ff @(posedge clk) begin
    tag_q   <= tag_mem[rd_addr];
    stamp_q <= stamp_mem[rd_addr];
    flag_q  <= flag_mem[rd_addr];
    if (stamp_we) begin
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (tag_we) begin
      tag_mem[wr_addr] <= code_r;
    end
    if (flag_we) begin
      flag_mem[wr_addr] <= wr_flag;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    pidx_nxt       = pidx_r;
    act_nxt        = act_r;
    code_nxt       = code_r;
    best_stamp_nxt = best_stamp_r;
    best_idx_nxt   = best_idx_r;
    best_tag_nxt   = best_tag_r;
    found_nxt      = found_r;
    slot_nxt       = slot_r;
    slot_flag_nxt  = slot_flag_r;
    clr_reply_nxt  = clr_reply_r;
    stamp_cnt_nxt  = stamp_cnt_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    stamp_we = 1'b0;
    tag_we   = 1'b0;
    flag_we  = 1'b0;
    wr_addr  = upd_slot;
    wr_stamp = stamp_cnt_r;
    wr_flag  = 1'b0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          act_nxt  = in_chan.action;
          code_nxt = CODE_BITS'(in_chan.glyph_code);
          res_nxt  = '0;
          unique case (in_chan.action) inside
            ACT_LOOKUP, ACT_BITMAP: begin
              cnt_nxt   = '0;
              pend_nxt  = 1'b0;
              found_nxt = 1'b0;
              state_nxt = ST_SCAN;
            end
            ACT_FLUSH: begin
              cnt_nxt       = '0;
              clr_reply_nxt = 1'b1;
              stamp_cnt_nxt = STAMP_BITS'(1);
              state_nxt     = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end

      ST_CLEAR: begin
        stamp_we = 1'b1;
        flag_we  = 1'b1;
        wr_addr  = cnt_r[IDX_W-1:0];
        wr_stamp = '0;
        wr_flag  = 1'b0;
        cnt_nxt  = cnt_r + cnt_t'(1);
        if (cnt_r[IDX_W-1:0] == IDX_W'(ENTRIES - 1)) begin
          state_nxt = clr_reply_r ? ST_EMIT : ST_IDLE;
        end
      end

      ST_SCAN: begin
        // Entry pidx_r is on the read data this cycle; the next address goes out.
        if (pend_r) begin
          if (found_now) begin
            found_nxt     = 1'b1;
            slot_nxt      = pidx_r;
            slot_flag_nxt = flag_q;
            state_nxt     = ST_UPDATE;
          end else begin
            // Strictly smaller stamp wins, so ties stay with the lowest index.
            if ((pidx_r == '0) || (best_stamp_r > stamp_q)) begin
              best_stamp_nxt = stamp_q;
              best_idx_nxt   = pidx_r;
              best_tag_nxt   = tag_q;
            end
            if (last_entry) begin
              state_nxt = ST_UPDATE;
            end
          end
        end
        if (cnt_r < cnt_t'(ENTRIES)) begin
          pend_nxt = 1'b1;
          pidx_nxt = rd_addr;
          cnt_nxt  = cnt_r + cnt_t'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end

      ST_UPDATE: begin
        stamp_we = 1'b1;
        tag_we   = !found_r;
        if (found_r) begin
          flag_we = (act_r == ACT_BITMAP) && !slot_flag_r;
          wr_flag = 1'b1;
        end else begin
          flag_we = 1'b1;
          wr_flag = (act_r == ACT_BITMAP);
        end
        if (stamp_cnt_r != '1) begin
          stamp_cnt_nxt = stamp_cnt_r + stamp_t'(1);
        end
        res_nxt.hit           = found_r;
        res_nxt.slot_index    = SLOT_W'(upd_slot);
        res_nxt.evicted_valid = evict;
        res_nxt.evicted_code  = evict ? GLYPH_W'(best_tag_r) : '0;
        res_nxt.needs_render  = (act_r == ACT_BITMAP) && (!found_r || !slot_flag_r);
        state_nxt             = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_nxt       = res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      clr_reply_r <= 1'b0;
      stamp_cnt_r <= STAMP_BITS'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      clr_reply_r <= clr_reply_nxt;
      stamp_cnt_r <= stamp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pidx_r       <= pidx_nxt;
    act_r        <= act_nxt;
    code_r       <= code_nxt;
    best_stamp_r <= best_stamp_nxt;
    best_idx_r   <= best_idx_nxt;
    best_tag_r   <= best_tag_nxt;
    slot_r       <= slot_nxt;
    slot_flag_r  <= slot_flag_nxt;
    res_r        <= res_nxt;
    out_r        <= out_nxt;
  end

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.hit           = out_r.hit;
  assign out_chan.slot_index    = out_r.slot_index;
  assign out_chan.evicted_valid = out_r.evicted_valid;
  assign out_chan.evicted_code  = out_r.evicted_code;
  assign out_chan.needs_render  = out_r.needs_render;

  // The stamp counter never hands out zero, which would mark an entry empty.
  a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    stamp_cnt_r != '0)
    else $error("stamp counter reached zero");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.hit |-> !out_r.evicted_valid)
    else $error("hit result reports an evicted entry");

  // The memories are never written while the scan reads them.
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> !stamp_we && !tag_we && !flag_we)
    else $error("memory write during scan");

  // A finished lookup always leaves the output register loaded.
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT && state_nxt == ST_IDLE |=> out_valid_r)
    else $error("result lost when leaving emit");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for glyph_lru_cache_policy_core
// A scoreboard class keeps a shadow copy of the tags, stamps and rendered flags
// and works out the outcome of every accepted request, which is then checked
// field by field against the result channel. A directed opening covers hits,
// misses, render marking, flush and the unused action code. Random traffic
// follows, drawn mostly from a working set near the cache size, in four phases
// of sender and receiver idling. The stamp is built narrow so that the counter
// saturates within the run.
// ----------------------------------------------------------------------------
module testbench;
  import glc_pkg::*;

  localparam int ENTRIES        = 256;
  localparam int CODE_BITS      = 16;
  // An 8-bit stamp reaches saturation after 254 accesses without a flush.
  localparam int STAMP_BITS     = 8;
  localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;
  localparam action_t ACT_UNUSED = 2'd3;
  localparam int POOL_SIZE      = 300;
  localparam int RECENT_DEPTH   = 48;
  localparam int PHASE_ITEMS    = 175;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRINT_LIMIT    = 40;

  typedef struct packed {
    logic   hit;
    slot_t  slot_index;
    logic   evicted_valid;
    glyph_t evicted_code;
    logic   needs_render;
  } access_outcome_t;

  class glyph_cache_scoreboard;
    glyph_t                tag_copy[ENTRIES];
    logic [STAMP_BITS-1:0] stamp_copy[ENTRIES];
    bit                    rendered_copy[ENTRIES];
    logic [STAMP_BITS-1:0] stamp_next;
    access_outcome_t       outcome_queue[$];
    int                    request_ids[$];
    int requests, hits, misses, evictions, renders, flushes, unused_codes;
    int saturated, results, mismatches;

    function new();
      foreach (tag_copy[i]) begin
        tag_copy[i]      = '0;
        stamp_copy[i]    = '0;
        rendered_copy[i] = 1'b0;
      end
      stamp_next = 1;
    endfunction

    function int pending_count();
      return outcome_queue.size();
    endfunction

    task report_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) begin
        $display("[%0t] MISMATCH: %s", $realtime, msg);
      end
      mismatches++;
    endtask

    // Hand out the current stamp; the counter holds once it reaches its maximum.
    function logic [STAMP_BITS-1:0] take_stamp();
      logic [STAMP_BITS-1:0] s;
      s = stamp_next;
      if (stamp_next != STAMP_MAX) begin
        stamp_next++;
      end else begin
        saturated++;
      end
      return s;
    endfunction

    function void note_request(action_t act, glyph_t code);
      access_outcome_t r;
      int slot;
      int victim;
      bit found;
      r = '0;
      slot = 0;
      victim = 0;
      found = 1'b0;
      requests++;
      if (act == ACT_FLUSH) begin
        foreach (stamp_copy[i]) stamp_copy[i] = '0;
        stamp_next = 1;
        flushes++;
      end else if (act == ACT_LOOKUP || act == ACT_BITMAP) begin
        // Empty entries carry stamp zero, so they win the victim search first.
        for (int i = 0; i < ENTRIES && !found; i++) begin
          if (stamp_copy[i] != 0 && tag_copy[i] == code) begin
            found = 1'b1;
            slot = i;
          end else if (stamp_copy[victim] > stamp_copy[i]) begin
            victim = i;
          end
        end
        if (found) begin
          r.hit = 1'b1;
          hits++;
        end else begin
          slot = victim;
          misses++;
          if (stamp_copy[slot] != 0) begin
            r.evicted_valid = 1'b1;
            r.evicted_code  = tag_copy[slot];
            evictions++;
          end
          tag_copy[slot]      = code;
          rendered_copy[slot] = 1'b0;
        end
        stamp_copy[slot] = take_stamp();
        if (act == ACT_BITMAP && !rendered_copy[slot]) begin
          r.needs_render      = 1'b1;
          rendered_copy[slot] = 1'b1;
          renders++;
        end
        r.slot_index = slot_t'(slot);
      end else begin
        unused_codes++;
      end
      outcome_queue.push_back(r);
      request_ids.push_back(requests);
    endfunction

    task check_outcome(access_outcome_t seen);
      access_outcome_t want;
      int id;
      results++;
      if (outcome_queue.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request waiting", results));
        return;
      end
      want = outcome_queue.pop_front();
      id   = request_ids.pop_front();
      if (seen.hit !== want.hit)
        report_mismatch($sformatf("request %0d hit %b, expected %b", id, seen.hit, want.hit));
      if (seen.slot_index !== want.slot_index)
        report_mismatch($sformatf("request %0d slot_index %0d, expected %0d",
                                  id, seen.slot_index, want.slot_index));
      if (seen.evicted_valid !== want.evicted_valid)
        report_mismatch($sformatf("request %0d evicted_valid %b, expected %b",
                                  id, seen.evicted_valid, want.evicted_valid));
      if (seen.evicted_code !== want.evicted_code)
        report_mismatch($sformatf("request %0d evicted_code %h, expected %h",
                                  id, seen.evicted_code, want.evicted_code));
      if (seen.needs_render !== want.needs_render)
        report_mismatch($sformatf("request %0d needs_render %b, expected %b",
                                  id, seen.needs_render, want.needs_render));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  glc_in_if  in_chan ();
  glc_out_if out_chan ();

  glyph_lru_cache_policy_core #(
    .ENTRIES   (ENTRIES),
    .STAMP_BITS(STAMP_BITS),
    .CODE_BITS (CODE_BITS)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan.sink),
    .out_chan(out_chan.source)
  );

  glyph_cache_scoreboard sb;
  int     send_idle_pct = 0;
  int     stall_pct     = 0;
  int     quiet_cycles  = 0;
  glyph_t code_pool[POOL_SIZE];
  glyph_t recent_codes[$];

  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    access_outcome_t seen;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      seen.hit           = out_chan.hit;
      seen.slot_index    = out_chan.slot_index;
      seen.evicted_valid = out_chan.evicted_valid;
      seen.evicted_code  = out_chan.evicted_code;
      seen.needs_render  = out_chan.needs_render;
      sb.check_outcome(seen);
    end
  end

  always @(posedge clk) begin
    if ((in_chan.valid === 1'b1 && in_chan.ready === 1'b1) ||
        (out_chan.valid === 1'b1 && out_chan.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] no item moved for %0d cycles", $realtime, quiet_cycles);
      $display("glyph_lru_cache_policy_core verification failed");
      $finish;
    end
  end

  // Holds valid until the item is taken; valid stays high into the next call.
  task automatic send_request(action_t act, glyph_t code);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.action     <= act;
    in_chan.glyph_code <= code;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    sb.note_request(act, code);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_request(ACT_LOOKUP, 16'h0000);
    send_request(ACT_LOOKUP, 16'hFFFF);
    send_request(ACT_BITMAP, 16'hFFFF);
    send_request(ACT_BITMAP, 16'hFFFF);
    send_request(ACT_BITMAP, 16'h8000);
    send_request(ACT_LOOKUP, 16'h0000);
    send_request(ACT_BITMAP, 16'h0000);
    send_request(ACT_UNUSED, 16'hFFFF);
    send_request(ACT_UNUSED, 16'h0000);
    send_request(ACT_FLUSH,  16'h5A5A);
    // After a flush the old tag is invisible: a miss that reloads and re-renders.
    send_request(ACT_BITMAP, 16'hFFFF);
    send_request(ACT_LOOKUP, 16'h0001);
    send_request(ACT_LOOKUP, 16'h7FFF);
    send_request(ACT_LOOKUP, 16'h00FF);
    send_request(ACT_BITMAP, 16'hFF00);
    send_request(ACT_LOOKUP, 16'hFFFF);
    send_request(ACT_FLUSH,  16'hFFFF);
    send_request(ACT_BITMAP, 16'h0001);
  endtask

  task automatic run_random_phase(int count);
    action_t act;
    glyph_t  code;
    int      roll;
    int      sent;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(599);
      if (roll < 2) begin
        act = ACT_FLUSH;
      end else if (roll < 14) begin
        act = ACT_UNUSED;
      end else begin
        act = $urandom_range(1) ? ACT_BITMAP : ACT_LOOKUP;
      end
      // Recent codes mostly hit; the pool is a bit larger than the cache and evicts.
      roll = $urandom_range(99);
      if (roll < 45 && recent_codes.size() > 0) begin
        code = recent_codes[$urandom_range(recent_codes.size() - 1)];
      end else if (roll < 85) begin
        code = code_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        code = glyph_t'($urandom);
      end
      send_request(act, code);
      if (act != ACT_UNUSED) sent++;
      if (act == ACT_LOOKUP || act == ACT_BITMAP) begin
        recent_codes.push_back(code);
        if (recent_codes.size() > RECENT_DEPTH) void'(recent_codes.pop_front());
      end
    end
  endtask

  initial begin : stimulus
    int idle_plan[4];
    int stall_plan[4];
    idle_plan  = '{0, 74, 0, 8};
    stall_plan = '{0, 0, 74, 8};
    sb = new();
    in_chan.valid      = 1'b0;
    in_chan.action     = ACT_LOOKUP;
    in_chan.glyph_code = '0;
    foreach (code_pool[i]) code_pool[i] = glyph_t'($urandom);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    drain_results();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_plan[p];
      stall_pct     = stall_plan[p];
      run_random_phase(PHASE_ITEMS);
      drain_results();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (sb.pending_count() != 0) begin
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending_count()));
    end
    $display("Covered %0d requests: %0d hits, %0d misses, %0d evictions, %0d renders,",
             sb.requests, sb.hits, sb.misses, sb.evictions, sb.renders);
    $display("  %0d flushes, %0d unused actions, %0d saturated stamps; %0d mismatches",
             sb.flushes, sb.unused_codes, sb.saturated, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("glyph_lru_cache_policy_core verification clean");
    end else begin
      $display("glyph_lru_cache_policy_core verification failed");
    end
    $finish;
  end

endmodule
